### rtl/core/ssh_pkg.sv
package ssh_pkg;

	localparam int WordW = 32;
	localparam int ChainN = 8;
	localparam int WinN = 16;
	localparam int RoundN = 64;

	typedef logic [WordW-1:0] word_t;
	typedef logic [$clog2(RoundN)-1:0] round_t;
	typedef logic [$clog2(ChainN)-1:0] widx_t;

	// control from the sequencer to the round datapath
	typedef struct packed {
		logic start;   // load working words from the chaining words
		logic step;    // run one compression round
		logic fold;    // add working words into the chaining words
		logic reinit;  // back to the initial hash values
	} core_ctl_t;

	localparam logic [7:0] PadMark = 8'h80;
	localparam logic [5:0] LenPos = 6'd56;

	localparam word_t RoundK [RoundN] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
		32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
		32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
		32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
		32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
		32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
		32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
		32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
		32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
		32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
		32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
	};

	localparam word_t InitH [ChainN] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	function automatic word_t rotr(input word_t x, input int n);
		return (x >> n) | (x << (WordW - n));
	endfunction

	function automatic word_t big_sig0(input word_t x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t big_sig1(input word_t x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t small_sig0(input word_t x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t small_sig1(input word_t x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

### rtl/core/sha256_stream_hasher_top.sv
// SHA-256 hasher for a byte stream. Each input beat carries one message byte in
// s_tdata, with s_tuser marking the byte as present and s_tlast ending the message;
// a last beat without a byte is allowed, so an empty message can be hashed. Beats
// with or without a byte are taken while idle, and the byte that fills a 64-byte
// block starts a compression: 64 rounds on the single round datapath, then an add
// into the chaining words. At the end of a message the padding is fed one byte a
// cycle up to the end of the block, and each padded block is compressed the same
// way; when the length does not fit, a second block of 64 padding bytes follows, so
// the tail takes at most two compressions. The digest then leaves as eight beats,
// most significant word first, word position in m_tuser and m_tlast on the eighth.
// s_tready stays low from the filling byte or the end of message until the block is
// idle again; after the last digest beat the hasher holds its initial state.
module sha256_stream_hasher_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] byte_present
	input  logic        s_tlast,   // end_of_message
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] digest_word
	output logic [2:0]  m_tuser,   // [2:0] word_index
	output logic        m_tlast    // last_word
);
	import ssh_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_PAD  = 5'b00010,
		ST_RUN  = 5'b00100,
		ST_FOLD = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t      state_q;
	logic [5:0]  fill_q;
	logic [63:0] total_q;
	logic [63:0] total_next;
	logic [63:0] len_q;
	logic [23:0] part_q;
	round_t      round_q;
	widx_t       oidx_q;
	logic        end_pend_q;
	logic        mark_q;
	logic        len_ok_q;
	logic        final_q;

	logic        s_acc;
	logic        m_acc;
	logic        feed;
	logic [7:0]  feed_byte;
	logic        len_byte;
	logic        push;
	word_t       push_word;
	word_t       w_cur;
	word_t       chain_word;
	core_ctl_t   ctl;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc = s_tvalid && s_tready;
	assign m_tvalid = (state_q == ST_OUT);
	assign m_acc = m_tvalid && m_tready;
	assign m_tdata = chain_word;
	assign m_tuser = oidx_q;
	assign m_tlast = (oidx_q == widx_t'(ChainN - 1));

	assign total_next = total_q + 64'(s_tuser);

	// byte source: message byte when idle, padding byte in the pad state
	assign len_byte = mark_q && len_ok_q && (fill_q >= LenPos);
	always_comb begin
		feed = 1'b0;
		feed_byte = s_tdata;
		if (state_q == ST_IDLE) begin
			feed = s_acc && s_tuser;
		end else if (state_q == ST_PAD) begin
			feed = 1'b1;
			if (!mark_q) begin
				feed_byte = PadMark;
			end else if (len_byte) begin
				feed_byte = len_q[63:56];
			end else begin
				feed_byte = 8'h00;
			end
		end
	end

	// big-endian word assembly into the schedule window
	assign push = feed && (fill_q[1:0] == 2'd3);
	assign push_word = {part_q, feed_byte};

	always_ff @(posedge clk) begin
		if (feed) begin
			part_q <= push_word[23:0];
		end
	end

	// datapath control
	always_comb begin
		ctl = '0;
		ctl.start = feed && (fill_q == 6'd63);
		ctl.step = (state_q == ST_RUN);
		ctl.fold = (state_q == ST_FOLD);
		ctl.reinit = m_acc && m_tlast;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			total_q <= '0;
			round_q <= '0;
			oidx_q <= '0;
			end_pend_q <= 1'b0;
			mark_q <= 1'b0;
			len_ok_q <= 1'b0;
			final_q <= 1'b0;
			len_q <= '0;
		end else begin
			if (feed) begin
				fill_q <= fill_q + 6'd1;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						total_q <= total_next;
						if (s_tlast) begin
							len_q <= {total_next[60:0], 3'b000};
							mark_q <= 1'b0;
							len_ok_q <= 1'b0;
						end
						if (s_tuser && fill_q == 6'd63) begin
							state_q <= ST_RUN;
							round_q <= '0;
							end_pend_q <= s_tlast;
							final_q <= 1'b0;
						end else if (s_tlast) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					if (!mark_q) begin
						mark_q <= 1'b1;
						if (fill_q < LenPos) begin
							len_ok_q <= 1'b1;
						end
					end
					if (len_byte) begin
						len_q <= {len_q[55:0], 8'h00};
					end
					if (fill_q == 6'd63) begin
						state_q <= ST_RUN;
						round_q <= '0;
						end_pend_q <= 1'b1;
						final_q <= mark_q && len_ok_q;
					end
				end
				ST_RUN: begin
					round_q <= round_q + round_t'(1);
					if (round_q == round_t'(RoundN - 1)) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					if (final_q) begin
						state_q <= ST_OUT;
						oidx_q <= '0;
					end else if (end_pend_q) begin
						state_q <= ST_PAD;
						if (mark_q) begin
							len_ok_q <= 1'b1;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (m_acc) begin
						oidx_q <= oidx_q + widx_t'(1);
						if (m_tlast) begin
							state_q <= ST_IDLE;
							total_q <= '0;
							fill_q <= '0;
							end_pend_q <= 1'b0;
							mark_q <= 1'b0;
							len_ok_q <= 1'b0;
							final_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	ssh_msg_sched u_sched (
		.clk       (clk),
		.push      (push),
		.push_word (push_word),
		.step      (ctl.step),
		.w_cur     (w_cur)
	);

	ssh_round_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.round      (round_q),
		.w_cur      (w_cur),
		.sel        (oidx_q),
		.chain_word (chain_word)
	);

endmodule

### rtl/core/ssh_msg_sched.sv
module ssh_msg_sched (
	input  logic           clk,
	input  logic           push,
	input  ssh_pkg::word_t push_word,
	input  logic           step,
	output ssh_pkg::word_t w_cur
);
	import ssh_pkg::*;

	// sixteen-word window: doubles as the block buffer while bytes arrive
	word_t win_q [WinN];
	word_t w_new;

	// next schedule word from the window taps
	assign w_new = win_q[0] + small_sig0(win_q[1]) + win_q[9] + small_sig1(win_q[14]);
	assign w_cur = win_q[0];

	// shift in either a filled message word or a fresh schedule word
	always_ff @(posedge clk) begin
		if (push || step) begin
			for (int i = 0; i < WinN - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[WinN-1] <= push ? push_word : w_new;
		end
	end

endmodule

### rtl/core/ssh_round_core.sv
module ssh_round_core (
	input  logic               clk,
	input  logic               arst_n,
	input  ssh_pkg::core_ctl_t ctl,
	input  ssh_pkg::round_t    round,
	input  ssh_pkg::word_t     w_cur,
	input  ssh_pkg::widx_t     sel,
	output ssh_pkg::word_t     chain_word
);
	import ssh_pkg::*;

	word_t chain_q [ChainN];
	word_t v_q [ChainN];
	word_t t1;
	word_t t2;
	word_t ch_w;
	word_t maj_w;

	// one compression round
	assign ch_w = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign maj_w = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1 = v_q[7] + big_sig1(v_q[4]) + ch_w + RoundK[round] + w_cur;
	assign t2 = big_sig0(v_q[0]) + maj_w;

	assign chain_word = chain_q[sel];

	// working words
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			for (int i = 0; i < ChainN; i++) begin
				v_q[i] <= chain_q[i];
			end
		end else if (ctl.step) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	// chaining words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ChainN; i++) begin
				chain_q[i] <= InitH[i];
			end
		end else if (ctl.reinit) begin
			for (int i = 0; i < ChainN; i++) begin
				chain_q[i] <= InitH[i];
			end
		end else if (ctl.fold) begin
			for (int i = 0; i < ChainN; i++) begin
				chain_q[i] <= chain_q[i] + v_q[i];
			end
		end
	end

endmodule

### sim/tb_sha256_stream_hasher_top.sv
`timescale 1ns / 1ps

module tb_sha256_stream_hasher_top;

	localparam int RandomItems = 200;
	localparam int TailCycles = 200;
	localparam int HoldCycles = 300;
	localparam logic [7:0] PadByte = 8'h80;
	localparam int LenAt = 56;

	// round constants and initial chaining words of sha-256
	localparam logic [31:0] RoundConst [64] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
		32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
		32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
		32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
		32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
		32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
		32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
		32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
		32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
		32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
		32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
	};
	localparam logic [31:0] StartHash [8] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	// message lengths around the padding and block boundaries
	localparam int EdgeLen [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

	// directed beats; known digests typed in for the empty message and "abc"
	typedef struct packed {
		logic [7:0]   data;
		logic         present;
		logic         eom;
		logic         known;
		logic [255:0] digest;
	} plan_row_t;

	localparam int PlanLen = 13;
	localparam plan_row_t Plan [PlanLen] = '{
		// no byte, no end: ignored
		'{8'hFF, 1'b0, 1'b0, 1'b0, 256'h0},
		// empty message
		'{8'h00, 1'b0, 1'b1, 1'b1,
			256'hE3B0C44298FC1C149AFBF4C8996FB92427AE41E4649B934CA495991B7852B855},
		// "abc"
		'{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
		'{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
		'{8'h63, 1'b1, 1'b1, 1'b1,
			256'hBA7816BF8F01CFEA414140DE5DAE2223B00361A396177A9CB410FF61F20015AD},
		// ignored beat inside a message, then an end beat without a byte
		'{8'h00, 1'b1, 1'b0, 1'b0, 256'h0},
		'{8'h5A, 1'b0, 1'b0, 1'b0, 256'h0},
		'{8'hFF, 1'b1, 1'b0, 1'b0, 256'h0},
		'{8'hA5, 1'b0, 1'b1, 1'b0, 256'h0},
		// single byte messages at both extremes
		'{8'hFF, 1'b1, 1'b1, 1'b0, 256'h0},
		'{8'h00, 1'b1, 1'b1, 1'b0, 256'h0},
		// stray beat, then an empty message again
		'{8'h3C, 1'b0, 1'b0, 1'b0, 256'h0},
		'{8'hC3, 1'b0, 1'b1, 1'b0, 256'h0}
	};

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  pos;
		logic        last;
	} digest_beat_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] data_byte
	logic        s_tuser;   // [0] byte_present
	logic        s_tlast;   // end_of_message
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // [31:0] digest_word
	logic [2:0]  m_tuser;   // [2:0] word_index
	logic        m_tlast;   // last_word

	digest_beat_t digest_q [$];
	int errors = 0;
	int beats_sent = 0;
	int words_seen = 0;

	// hash state kept alongside the block
	logic [31:0] chain [8];
	logic [7:0]  blk [64];
	int          fill;
	logic [63:0] byte_count;
	logic [31:0] digest_words [8];

	sha256_stream_hasher_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] rot_right(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void hash_restart();
		for (int i = 0; i < 8; i++)
			chain[i] = StartHash[i];
		fill = 0;
		byte_count = '0;
	endfunction

	// one 64-round compression of the block buffer into the chaining words
	function automatic void compress_block();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] s0, s1, t1, t2;
		for (int t = 0; t < 16; t++)
			w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
		for (int t = 16; t < 64; t++) begin
			s0 = rot_right(w[t-15], 7) ^ rot_right(w[t-15], 18) ^ (w[t-15] >> 3);
			s1 = rot_right(w[t-2], 17) ^ rot_right(w[t-2], 19) ^ (w[t-2] >> 10);
			w[t] = w[t-16] + s0 + w[t-7] + s1;
		end
		for (int i = 0; i < 8; i++)
			v[i] = chain[i];
		for (int t = 0; t < 64; t++) begin
			t1 = v[7] + (rot_right(v[4], 6) ^ rot_right(v[4], 11) ^ rot_right(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[t] + w[t];
			t2 = (rot_right(v[0], 2) ^ rot_right(v[0], 13) ^ rot_right(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain[i] = chain[i] + v[i];
	endfunction

	// absorb one beat; on end of message pad, finish and leave the digest in digest_words
	// the bit length wraps only past 2^61 bytes, far beyond any simulated message
	function automatic bit absorb_beat(input logic [7:0] data, input logic present,
			input logic eom);
		logic [63:0] bit_len;
		if (present) begin
			blk[fill] = data;
			fill++;
			byte_count = byte_count + 64'd1;
			if (fill == 64) begin
				compress_block();
				fill = 0;
			end
		end
		if (!eom)
			return 1'b0;
		bit_len = byte_count << 3;
		blk[fill] = PadByte;
		fill++;
		if (fill > LenAt) begin
			while (fill < 64) begin
				blk[fill] = 8'h00;
				fill++;
			end
			compress_block();
			fill = 0;
		end
		while (fill < LenAt) begin
			blk[fill] = 8'h00;
			fill++;
		end
		for (int i = 0; i < 8; i++)
			blk[LenAt + i] = bit_len[63 - 8*i -: 8];
		compress_block();
		for (int i = 0; i < 8; i++)
			digest_words[i] = chain[i];
		hash_restart();
		return 1'b1;
	endfunction

	function automatic bit idle_roll(input bit calm);
		return !calm && ($urandom_range(99) < 31);
	endfunction

	// offer one beat, wait for the handshake, then log the expected digest
	task automatic put_beat(input logic [7:0] data, input logic present, input logic eom,
			input logic known, input logic [255:0] digest);
		digest_beat_t d;
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tuser  <= present;
		s_tlast  <= eom;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (present || eom)
			beats_sent++;
		if (absorb_beat(data, present, eom)) begin
			for (int i = 0; i < 8; i++) begin
				d.word = known ? digest[255 - 32*i -: 32] : digest_words[i];
				d.pos  = 3'(i);
				d.last = (i == 7);
				digest_q.push_back(d);
			end
		end
		// random gap before the next beat, none in the calm stretch
		if (idle_roll(beats_sent >= 120 && beats_sent < 170)) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 8'($urandom);
			s_tuser  <= 1'($urandom);
			s_tlast  <= 1'($urandom);
			@(posedge clk);
			while (idle_roll(1'b0))
				@(posedge clk);
		end
	endtask

	// a message of random bytes, mostly short, sometimes near a block boundary
	task automatic send_message();
		int  len;
		bit  end_alone;
		logic tail;
		if ($urandom_range(5) == 0)
			len = EdgeLen[$urandom_range(7)];
		else
			len = $urandom_range(12);
		end_alone = (len == 0) || ($urandom_range(2) == 0);
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(9) == 0)
				put_beat(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
			tail = (k == len - 1) && !end_alone;
			put_beat(8'($urandom), 1'b1, tail, 1'b0, '0);
		end
		if (end_alone)
			put_beat(8'($urandom), 1'b0, 1'b1, 1'b0, '0);
	endtask

	// stimulus and end of run
	initial begin : stim
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = 8'h00;
		s_tuser  = 1'b0;
		s_tlast  = 1'b0;
		hash_restart();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int k = 0; k < PlanLen; k++)
			put_beat(Plan[k].data, Plan[k].present, Plan[k].eom, Plan[k].known, Plan[k].digest);
		while (beats_sent < PlanLen + RandomItems)
			send_message();
		s_tvalid <= 1'b0;
		while (digest_q.size() != 0)
			@(posedge clk);
		repeat (TailCycles) @(posedge clk);
		if (errors == 0)
			$display("tb_sha256_stream_hasher_top OK");
		else
			$display("tb_sha256_stream_hasher_top NOT OK");
		$finish;
	end

	// receiver backpressure, with one long hold-off so the input stalls
	initial begin : drain
		bit held;
		held = 1'b0;
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!held && words_seen >= 56) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
			end else begin
				m_tready <= !idle_roll(words_seen >= 80 && words_seen < 112);
			end
		end
	end

	// compare each digest beat against the oldest expectation
	always @(posedge clk) begin
		digest_beat_t exp_beat;
		if (arst_n && m_tvalid && m_tready) begin
			words_seen++;
			if (digest_q.size() == 0) begin
				errors++;
				$display("%0t unexpected digest beat: expected none, got %h pos %0d last %b",
					$time, m_tdata, m_tuser, m_tlast);
			end else begin
				exp_beat = digest_q.pop_front();
				if (m_tdata !== exp_beat.word) begin
					errors++;
					$display("%0t digest word mismatch: expected %h, got %h",
						$time, exp_beat.word, m_tdata);
				end
				if (m_tuser !== exp_beat.pos) begin
					errors++;
					$display("%0t word index mismatch: expected %0d, got %0d",
						$time, exp_beat.pos, m_tuser);
				end
				if (m_tlast !== exp_beat.last) begin
					errors++;
					$display("%0t last word flag mismatch: expected %b, got %b",
						$time, exp_beat.last, m_tlast);
				end
			end
		end
	end

	// watchdog
	initial begin : watchdog
		#5000000;
		$display("tb_sha256_stream_hasher_top NOT OK");
		$finish;
	end

endmodule
